@@ design/amwd_pkg.sv @@
// ----------------------------------------------------------------------------
// amwd_pkg
// Shared widths, register indexes, reset values and scaling constants for the
// accelerometer motion window detector.
// ----------------------------------------------------------------------------
package amwd_pkg;

    localparam int AXIS_W     = 16;
    localparam int ORIENT_W   = 7;
    localparam int DIFF_THR_W = 7;
    localparam int CNT_THR_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CNT_THR  = 1'd1;

    localparam logic [DIFF_THR_W-1:0] DIFF_THR_RST = 7'd3;
    localparam logic [CNT_THR_W-1:0]  CNT_THR_RST  = 6'd10;

    localparam int WINDOW_STEPS_DEF   = 50;
    localparam int WARMUP_SAMPLES_DEF = 199;

    // q = (|v| * RECIP_MULT) >> RECIP_SHIFT is exact for |v| <= 32768
    localparam int              RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd67109;
    localparam int              RECIP_SHIFT = 26;
    localparam int              QUOT_W      = 6;

endpackage

@@ design/amwd_scale.sv @@
// ----------------------------------------------------------------------------
// amwd_scale
// Signed 16-bit word divided by 1000, truncating toward zero, by reciprocal
// multiplication on the magnitude.
// ----------------------------------------------------------------------------
module amwd_scale
(
    input  logic signed [amwd_pkg::AXIS_W-1:0]   raw,
    output logic signed [amwd_pkg::ORIENT_W-1:0] scaled
);

    localparam int PROD_W = amwd_pkg::AXIS_W + amwd_pkg::RECIP_W;

    logic [amwd_pkg::AXIS_W:0]     ext;
    logic [amwd_pkg::AXIS_W:0]     mag;
    logic [PROD_W-1:0]             prod;
    logic [amwd_pkg::QUOT_W-1:0]   quot;
    logic [amwd_pkg::ORIENT_W-1:0] quot_ext;

    always_comb
    begin
        ext      = {raw[amwd_pkg::AXIS_W-1], raw};
        mag      = raw[amwd_pkg::AXIS_W-1] ? (~ext + 1'b1) : ext;
        prod     = PROD_W'(mag[amwd_pkg::AXIS_W-1:0]) * PROD_W'(amwd_pkg::RECIP_MULT);
        quot     = prod[amwd_pkg::RECIP_SHIFT +: amwd_pkg::QUOT_W];
        quot_ext = {1'b0, quot};
        scaled   = raw[amwd_pkg::AXIS_W-1] ? (~quot_ext + 1'b1) : quot_ext;
    end

endmodule

@@ design/accel_motion_window_detector.sv @@
// ----------------------------------------------------------------------------
// accel_motion_window_detector
// Scales three-axis samples by 1/1000 and flags motion from the count of
// large X steps over a sliding window.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while in_ready is high; each item
// passes through the input register and then the result register, and the
// mark shift line, running count and warm-up counter are all updated in that
// one pass. A stalled result holds the input register, so the input is refused
// only while both registers are full and out_ready is low. The first
// WARMUP_SAMPLES items update the window but give no result; every later item
// gives exactly one. Threshold writes apply to items that reach the mark stage
// after the write.
module accel_motion_window_detector
#(
    parameter int WINDOW_STEPS   = amwd_pkg::WINDOW_STEPS_DEF,
    parameter int WARMUP_SAMPLES = amwd_pkg::WARMUP_SAMPLES_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [amwd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [amwd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [amwd_pkg::AXIS_W-1:0]    raw_x,
    input  logic signed [amwd_pkg::AXIS_W-1:0]    raw_y,
    input  logic signed [amwd_pkg::AXIS_W-1:0]    raw_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  motion,
    output logic signed [amwd_pkg::ORIENT_W-1:0]  orient_x,
    output logic signed [amwd_pkg::ORIENT_W-1:0]  orient_y,
    output logic signed [amwd_pkg::ORIENT_W-1:0]  orient_z
);

    localparam int CNT_W  = $clog2(WINDOW_STEPS + 1);
    localparam int WARM_W = $clog2(WARMUP_SAMPLES + 1);
    localparam int CMP_W  = (CNT_W > amwd_pkg::CNT_THR_W) ? CNT_W : amwd_pkg::CNT_THR_W;
    localparam int DIFF_W = amwd_pkg::ORIENT_W + 1;

    logic [amwd_pkg::DIFF_THR_W-1:0]        diff_thr_reg;
    logic [amwd_pkg::CNT_THR_W-1:0]         cnt_thr_reg;
    logic                                   s1_valid_reg;
    logic signed [amwd_pkg::AXIS_W-1:0]     raw_x_reg;
    logic signed [amwd_pkg::AXIS_W-1:0]     raw_y_reg;
    logic signed [amwd_pkg::AXIS_W-1:0]     raw_z_reg;
    logic signed [amwd_pkg::ORIENT_W-1:0]   prev_x_reg;
    logic [WINDOW_STEPS-1:0]                marks_reg;
    logic [CNT_W-1:0]                       count_reg;
    logic [WARM_W-1:0]                      warm_reg;
    logic                                   out_valid_reg;
    logic                                   motion_reg;
    logic signed [amwd_pkg::ORIENT_W-1:0]   orient_x_reg;
    logic signed [amwd_pkg::ORIENT_W-1:0]   orient_y_reg;
    logic signed [amwd_pkg::ORIENT_W-1:0]   orient_z_reg;

    logic signed [amwd_pkg::ORIENT_W-1:0]   sx;
    logic signed [amwd_pkg::ORIENT_W-1:0]   sy;
    logic signed [amwd_pkg::ORIENT_W-1:0]   sz;
    logic [DIFF_W-1:0]                      diff;
    logic [DIFF_W-1:0]                      diff_mag;
    logic                                   mark;
    logic [WINDOW_STEPS-1:0]                marks_next;
    logic [CNT_W-1:0]                       count_next;
    logic                                   warm_done;
    logic [WARM_W-1:0]                      warm_next;
    logic                                   motion_next;
    logic                                   advance;
    logic                                   in_take;

    amwd_scale u_scale_x (.raw(raw_x_reg), .scaled(sx));
    amwd_scale u_scale_y (.raw(raw_y_reg), .scaled(sy));
    amwd_scale u_scale_z (.raw(raw_z_reg), .scaled(sz));

    always_comb
    begin
        advance  = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !s1_valid_reg || advance;
        in_take  = in_valid && in_ready;

        diff     = {sx[amwd_pkg::ORIENT_W-1], sx} - {prev_x_reg[amwd_pkg::ORIENT_W-1], prev_x_reg};
        diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        mark     = diff_mag >= DIFF_W'(diff_thr_reg);

        // oldest mark drops off the far end of the shift line
        marks_next  = {marks_reg[WINDOW_STEPS-2:0], mark};
        count_next  = count_reg - CNT_W'(marks_reg[WINDOW_STEPS-1]) + CNT_W'(mark);
        motion_next = CMP_W'(count_next) >= CMP_W'(cnt_thr_reg);

        warm_done = (warm_reg == WARM_W'(WARMUP_SAMPLES));
        warm_next = warm_done ? warm_reg : (warm_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_thr_reg  <= amwd_pkg::DIFF_THR_RST;
            cnt_thr_reg   <= amwd_pkg::CNT_THR_RST;
            s1_valid_reg  <= 1'b0;
            prev_x_reg    <= '0;
            marks_reg     <= '0;
            count_reg     <= '0;
            warm_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    amwd_pkg::REG_DIFF_THR: diff_thr_reg <= cfg_data;
                    amwd_pkg::REG_CNT_THR:  cnt_thr_reg  <= cfg_data[amwd_pkg::CNT_THR_W-1:0];
                    default: ;
                endcase
            end

            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                prev_x_reg    <= sx;
                marks_reg     <= marks_next;
                count_reg     <= count_next;
                warm_reg      <= warm_next;
                out_valid_reg <= warm_done;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            raw_x_reg <= raw_x;
            raw_y_reg <= raw_y;
            raw_z_reg <= raw_z;
        end
        if (advance && warm_done)
        begin
            motion_reg   <= motion_next;
            orient_x_reg <= sx;
            orient_y_reg <= sy;
            orient_z_reg <= sz;
        end
    end

    assign out_valid = out_valid_reg;
    assign motion    = motion_reg;
    assign orient_x  = orient_x_reg;
    assign orient_y  = orient_y_reg;
    assign orient_z  = orient_z_reg;

endmodule

@@ design/amwd_checker.sv @@
// ----------------------------------------------------------------------------
// amwd_checker
// Port-level checks for the accelerometer motion window detector.
// ----------------------------------------------------------------------------
module amwd_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  motion,
    input logic signed [amwd_pkg::ORIENT_W-1:0]  orient_x,
    input logic signed [amwd_pkg::ORIENT_W-1:0]  orient_y,
    input logic signed [amwd_pkg::ORIENT_W-1:0]  orient_z
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motion) && $stable(orient_x)
            && $stable(orient_y) && $stable(orient_z))
        else $error("stalled result changed");

    // with the result register empty the block always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("item refused while result register empty");

    // taken result never needs to wait for a refused input
    a_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("item refused while result taken");

    // scaled values lie in -32..32
    a_orient_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (orient_x >= -7'sd32) && (orient_x <= 7'sd32)
            && (orient_y >= -7'sd32) && (orient_y <= 7'sd32)
            && (orient_z >= -7'sd32) && (orient_z <= 7'sd32))
        else $error("orientation out of range");

endmodule

bind accel_motion_window_detector amwd_checker u_amwd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .motion    (motion),
    .orient_x  (orient_x),
    .orient_y  (orient_y),
    .orient_z  (orient_z)
);
